### rtl/core/utn_pkg.sv
// Shared types and constants of the uphill tangent normalizer.
// Depends on nothing; the front end, queue, back end and top use it by scoped names.
package utn_pkg;

    localparam int C_W       = 41;  // combined element, signed
    localparam int E_W       = 24;  // energy field
    localparam int V_W       = 16;  // vector element field
    localparam int W_W       = 25;  // weight
    localparam int P_W       = 40;  // weight times element
    localparam int NORM_BITS = 24;  // scaled magnitude width
    localparam int SQ_W      = 48;
    localparam int SUM_W     = 56;
    localparam int ROOT_W    = 28;
    localparam int Q_W       = 15;
    localparam int NUM_W     = 39;
    localparam int ONE_SHIFT = 14;  // 16384 is one in Q1.14
    localparam int LEN_W     = 6;

    typedef struct packed {
        logic signed [C_W-1:0] c;
        logic                  last;
    } elem_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WGT,
        F_MUL,
        F_SUM
    } front_state_t;

    typedef enum logic [3:0] {
        B_LOAD,
        B_LEN,
        B_SQ_RD,
        B_SQ_MUL,
        B_SQ_ACC,
        B_ROOT,
        B_EM_RD,
        B_EM_SCALE,
        B_EM_DIV,
        B_EM_OUT
    } back_state_t;

endpackage

### rtl/core/utn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module utn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/utn_front.sv
// Front end: accepts items, picks the weights on the first item of a run and
// forms the combined element. Depends on utn_pkg.
module utn_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [utn_pkg::E_W-1:0]   energy_center,
    input  logic signed [utn_pkg::E_W-1:0]   energy_before,
    input  logic signed [utn_pkg::E_W-1:0]   energy_after,
    input  logic signed [utn_pkg::V_W-1:0]   left_component,
    input  logic signed [utn_pkg::V_W-1:0]   right_component,
    input  logic                             last_element,
    output logic                             push_valid,
    output utn_pkg::elem_t                   push_data,
    input  logic                             fifo_full
);

    utn_pkg::front_state_t state_reg, state_next;
    logic first_reg, first_next;
    logic signed [utn_pkg::E_W-1:0] ec_reg, eb_reg, ea_reg;
    logic signed [utn_pkg::V_W-1:0] l_reg, r_reg;
    logic last_reg;
    logic signed [utn_pkg::W_W-1:0] wl_reg, wl_next, wr_reg, wr_next;
    logic signed [utn_pkg::P_W-1:0] p1_reg, p2_reg;
    logic accept;

    logic signed [utn_pkg::W_W-1:0] c25, b25, a25, dl, dr, vmax, vmin;
    logic extremum;

    assign accept = (state_reg == utn_pkg::F_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= utn_pkg::F_IDLE;
            first_reg <= 1'b1;
            wl_reg    <= '0;
            wr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            wl_reg    <= wl_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ec_reg   <= energy_center;
            eb_reg   <= energy_before;
            ea_reg   <= energy_after;
            l_reg    <= left_component;
            r_reg    <= right_component;
            last_reg <= last_element;
        end
        if (state_reg == utn_pkg::F_MUL)
        begin
            p1_reg <= utn_pkg::P_W'(wl_reg) * utn_pkg::P_W'(l_reg);
            p2_reg <= utn_pkg::P_W'(wr_reg) * utn_pkg::P_W'(r_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            utn_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = first_reg ? utn_pkg::F_WGT : utn_pkg::F_MUL;
                end
            end
            utn_pkg::F_WGT: state_next = utn_pkg::F_MUL;
            utn_pkg::F_MUL: state_next = utn_pkg::F_SUM;
            utn_pkg::F_SUM:
            begin
                if (!fifo_full)
                begin
                    state_next = utn_pkg::F_IDLE;
                end
            end
            default: state_next = utn_pkg::F_IDLE;
        endcase
    end

    // weight selection under the uphill rule
    always_comb
    begin
        c25 = {ec_reg[utn_pkg::E_W-1], ec_reg};
        b25 = {eb_reg[utn_pkg::E_W-1], eb_reg};
        a25 = {ea_reg[utn_pkg::E_W-1], ea_reg};
        dl  = (c25 >= b25) ? c25 - b25 : b25 - c25;
        dr  = (c25 >= a25) ? c25 - a25 : a25 - c25;
        vmax = (dl > dr) ? dl : dr;
        vmin = (dl > dr) ? dr : dl;
        extremum = ((c25 >= b25) && (c25 >= a25)) || ((c25 <= b25) && (c25 <= a25));
        first_next = first_reg;
        wl_next = wl_reg;
        wr_next = wr_reg;
        if (accept)
        begin
            first_next = last_element;
        end
        if (state_reg == utn_pkg::F_WGT)
        begin
            if (extremum)
            begin
                wl_next = (b25 > a25) ? vmax : vmin;
                wr_next = (b25 > a25) ? -vmin : -vmax;
            end
            else if (b25 > a25)
            begin
                wl_next = utn_pkg::W_W'(1);
                wr_next = '0;
            end
            else
            begin
                wl_next = '0;
                wr_next = -utn_pkg::W_W'(1);
            end
        end
    end

    // outputs
    always_comb
    begin
        in_stall       = (state_reg != utn_pkg::F_IDLE);
        push_valid     = (state_reg == utn_pkg::F_SUM);
        push_data.c    = {p1_reg[utn_pkg::P_W-1], p1_reg} + {p2_reg[utn_pkg::P_W-1], p2_reg};
        push_data.last = last_reg;
    end

endmodule

### rtl/core/utn_fifo.sv
// Four-entry queue of combined elements between front and back end.
// Depends on utn_pkg.
module utn_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  utn_pkg::elem_t push_data,
    output logic           full,
    input  logic           pop,
    output utn_pkg::elem_t head,
    output logic           not_empty
);

    utn_pkg::elem_t slot_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic do_push, do_pop;

    assign full      = (count_reg == 3'd4);
    assign not_empty = (count_reg != 3'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {2'b0, do_push} - {2'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/utn_back.sv
// Back end: stores elements, finds the scale, sums squares, takes the
// square root and divides each element by it. Depends on utn_pkg, utn_ram.
module utn_back #(
    parameter int MAX_DIM = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  utn_pkg::elem_t                 head,
    input  logic                           not_empty,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [utn_pkg::V_W-1:0] tangent_component,
    output logic                           zero_norm,
    output logic                           last_result
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    utn_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] k_reg, k_next;
    logic [utn_pkg::C_W-1:0] m_reg, m_next;
    logic [utn_pkg::LEN_W-1:0] b_reg, b_next;
    logic zero_reg, zero_next;
    logic [utn_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [utn_pkg::SUM_W-1:0] sum_reg, sum_next, v_reg, v_next;
    logic [utn_pkg::SUM_W-1:0] res_reg, res_next, bit_reg, bit_next;
    logic [utn_pkg::ROOT_W-1:0] root_reg, root_next, rem_reg, rem_next;
    logic [utn_pkg::NUM_W-1:0] num_reg, num_next;
    logic [utn_pkg::Q_W-1:0] q_reg, q_next;
    logic [3:0] step_reg, step_next;
    logic sign_reg, sign_next;
    logic out_valid_reg, out_valid_next;
    logic signed [utn_pkg::V_W-1:0] tc_reg, tc_next;
    logic zn_reg, zn_next, lr_reg, lr_next;

    logic we;
    logic [utn_pkg::C_W-1:0] rd_data, head_mag, rd_mag;
    logic [utn_pkg::NORM_BITS-1:0] s;
    logic [utn_pkg::SUM_W-1:0] trial;
    logic [utn_pkg::ROOT_W:0] dtrial;
    logic last_k, can_load, room;

    function automatic logic [utn_pkg::C_W-1:0] mag_of(input logic [utn_pkg::C_W-1:0] v);
        mag_of = v[utn_pkg::C_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [utn_pkg::NORM_BITS-1:0] scale(
        input logic [utn_pkg::C_W-1:0]   a,
        input logic [utn_pkg::LEN_W-1:0] b
    );
        logic [utn_pkg::C_W-1:0] t;
        if (b > utn_pkg::LEN_W'(utn_pkg::NORM_BITS))
        begin
            t = a >> (b - utn_pkg::LEN_W'(utn_pkg::NORM_BITS));
        end
        else
        begin
            t = a << (utn_pkg::LEN_W'(utn_pkg::NORM_BITS) - b);
        end
        scale = t[utn_pkg::NORM_BITS-1:0];
    endfunction

    utn_ram #(
        .WIDTH (utn_pkg::C_W),
        .DEPTH (MAX_DIM),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (head.c),
        .raddr (k_reg),
        .rdata (rd_data)
    );

    assign head_mag = mag_of(head.c);
    assign rd_mag   = mag_of(rd_data);
    assign s        = scale(rd_mag, b_reg);
    assign last_k   = ((CW'(k_reg) + CW'(1)) == cnt_reg);
    assign can_load = !out_valid_reg || !out_stall;
    assign room     = (cnt_reg < CW'(MAX_DIM));
    assign trial    = res_reg + bit_reg;
    assign dtrial   = {rem_reg, num_reg[step_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= utn_pkg::B_LOAD;
            cnt_reg       <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        zero_reg <= zero_next;
        sq_reg   <= sq_next;
        sum_reg  <= sum_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        sign_reg <= sign_next;
        tc_reg   <= tc_next;
        zn_reg   <= zn_next;
        lr_reg   <= lr_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            utn_pkg::B_LOAD:
            begin
                if (not_empty && head.last)
                begin
                    state_next = utn_pkg::B_LEN;
                end
            end
            utn_pkg::B_LEN:
            begin
                if (m_reg == '0)
                begin
                    state_next = utn_pkg::B_EM_RD;
                end
                else if (m_reg[utn_pkg::C_W-1])
                begin
                    state_next = utn_pkg::B_SQ_RD;
                end
            end
            utn_pkg::B_SQ_RD:  state_next = utn_pkg::B_SQ_MUL;
            utn_pkg::B_SQ_MUL: state_next = utn_pkg::B_SQ_ACC;
            utn_pkg::B_SQ_ACC: state_next = last_k ? utn_pkg::B_ROOT : utn_pkg::B_SQ_RD;
            utn_pkg::B_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = utn_pkg::B_EM_RD;
                end
            end
            utn_pkg::B_EM_RD: state_next = utn_pkg::B_EM_SCALE;
            utn_pkg::B_EM_SCALE:
            begin
                state_next = zero_reg ? utn_pkg::B_EM_OUT : utn_pkg::B_EM_DIV;
            end
            utn_pkg::B_EM_DIV:
            begin
                if (step_reg == 4'd0)
                begin
                    state_next = utn_pkg::B_EM_OUT;
                end
            end
            utn_pkg::B_EM_OUT:
            begin
                if (can_load)
                begin
                    state_next = last_k ? utn_pkg::B_LOAD : utn_pkg::B_EM_RD;
                end
            end
            default: state_next = utn_pkg::B_LOAD;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        m_next    = m_reg;
        b_next    = b_reg;
        zero_next = zero_reg;
        sq_next   = sq_reg;
        sum_next  = sum_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        step_next = step_reg;
        sign_next = sign_reg;
        tc_next   = tc_reg;
        zn_next   = zn_reg;
        lr_next   = lr_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            utn_pkg::B_LOAD:
            begin
                if (not_empty)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        if (head_mag > m_reg)
                        begin
                            m_next = head_mag;
                        end
                    end
                    b_next = utn_pkg::LEN_W'(utn_pkg::C_W);
                end
            end
            utn_pkg::B_LEN:
            begin
                k_next   = '0;
                sum_next = '0;
                if (m_reg == '0)
                begin
                    zero_next = 1'b1;
                end
                else if (m_reg[utn_pkg::C_W-1])
                begin
                    zero_next = 1'b0;
                end
                else
                begin
                    m_next = m_reg << 1;
                    b_next = b_reg - utn_pkg::LEN_W'(1);
                end
            end
            utn_pkg::B_SQ_RD:
            begin
            end
            utn_pkg::B_SQ_MUL:
            begin
                sq_next = s * s;
            end
            utn_pkg::B_SQ_ACC:
            begin
                sum_next = sum_reg + utn_pkg::SUM_W'(sq_reg);
                if (last_k)
                begin
                    k_next   = '0;
                    v_next   = sum_reg + utn_pkg::SUM_W'(sq_reg);
                    res_next = '0;
                    bit_next = utn_pkg::SUM_W'(1) << 54;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            utn_pkg::B_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    root_next = res_reg[utn_pkg::ROOT_W-1:0];
                end
                else
                begin
                    if (v_reg >= trial)
                    begin
                        v_next   = v_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            utn_pkg::B_EM_RD:
            begin
            end
            utn_pkg::B_EM_SCALE:
            begin
                sign_next = rd_data[utn_pkg::C_W-1];
                q_next    = '0;
                step_next = 4'(utn_pkg::Q_W - 1);
                num_next  = {s, {utn_pkg::ONE_SHIFT{1'b0}}}
                          + utn_pkg::NUM_W'(root_reg >> 1);
                rem_next  = utn_pkg::ROOT_W'(num_next[utn_pkg::NUM_W-1:utn_pkg::Q_W]);
            end
            utn_pkg::B_EM_DIV:
            begin
                if (dtrial >= {1'b0, root_reg})
                begin
                    rem_next         = utn_pkg::ROOT_W'(dtrial - {1'b0, root_reg});
                    q_next[step_reg] = 1'b1;
                end
                else
                begin
                    rem_next = dtrial[utn_pkg::ROOT_W-1:0];
                end
                step_next = step_reg - 4'd1;
            end
            utn_pkg::B_EM_OUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    tc_next = sign_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                    zn_next = zero_reg;
                    lr_next = last_k;
                    if (last_k)
                    begin
                        cnt_next = '0;
                        m_next   = '0;
                        k_next   = '0;
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pop               = (state_reg == utn_pkg::B_LOAD) && not_empty;
        we                = pop && room;
        out_valid         = out_valid_reg;
        tangent_component = tc_reg;
        zero_norm         = zn_reg;
        last_result       = lr_reg;
    end

endmodule

### rtl/core/uphill_tangent_normalizer.sv
// Top level of the uphill tangent normalizer: front end, element queue,
// back end. Depends on utn_pkg, utn_front, utn_fifo, utn_back, utn_ram.
//
// Usage: feed one vector element per input item on the in_valid / in_stall
// channel; the three energies are taken from the first item of a run and
// ignored on later ones. last_element closes the run. The block then emits
// one item per stored element (at most MAX_DIM) on out_valid / out_stall,
// the unit tangent in Q1.14, with last_result on the final one.
// The front end takes one item at a time: it stalls the input while the
// item passes its weight step (first item of a run only), multiply and
// add, and until the queue takes the combined element. After the last
// item the back end finds the scale (one bit per cycle), sums the squares
// of the scaled elements by reading, squaring and accumulating each one,
// takes the two-bit-per-step square root, then runs the one-bit-per-cycle
// divider and emits each element in turn.
// A zero vector skips the sum, root and divider.
// Items keep being accepted into the four-entry queue while the back end
// works, until it fills.
// Reset clears the sequencers, the queue and the output valid; the element
// store needs no clearing since a run only reads entries it wrote.
// A stalled output holds its item; the back end waits, the queue fills, and
// the front end then stalls the input.
module uphill_tangent_normalizer #(
    parameter int MAX_DIM = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [utn_pkg::E_W-1:0] energy_center,
    input  logic signed [utn_pkg::E_W-1:0] energy_before,
    input  logic signed [utn_pkg::E_W-1:0] energy_after,
    input  logic signed [utn_pkg::V_W-1:0] left_component,
    input  logic signed [utn_pkg::V_W-1:0] right_component,
    input  logic                           last_element,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [utn_pkg::V_W-1:0] tangent_component,
    output logic                           zero_norm,
    output logic                           last_result
);

    logic           push_valid;
    utn_pkg::elem_t push_data;
    logic           fifo_full;
    utn_pkg::elem_t head;
    logic           not_empty;
    logic           pop;

    // classify and combine each item
    utn_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .energy_center   (energy_center),
        .energy_before   (energy_before),
        .energy_after    (energy_after),
        .left_component  (left_component),
        .right_component (right_component),
        .last_element    (last_element),
        .push_valid      (push_valid),
        .push_data       (push_data),
        .fifo_full       (fifo_full)
    );

    // decouple the two halves
    utn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    // store, normalize and emit
    utn_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .not_empty         (not_empty),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tangent_component (tangent_component),
        .zero_norm         (zero_norm),
        .last_result       (last_result)
    );

    // hold a combined element until the queue takes it
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && fifo_full |=> push_valid && $stable(push_data))
        else $error("combined element dropped while queue full");

    // a zero vector gives zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> tangent_component == '0)
        else $error("nonzero component with zero norm");

    // a unit tangent never exceeds one in magnitude
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tangent_component <= 16'sd16384) && (tangent_component >= -16'sd16384))
        else $error("tangent component out of range");

endmodule

### tb/uphill_tangent_normalizer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the uphill tangent normalizer: drives element runs
// with random gaps and output stalls and checks each tangent item against a
// local predictor. Depends on the uphill_tangent_normalizer RTL only.
module uphill_tangent_normalizer_tb;

    localparam int MAX_DIM  = 64;
    localparam int N_DIRECT = 12;

    // One tangent item as the block emits it.
    typedef struct packed {
        logic signed [15:0] comp;
        logic               zero;
        logic               last;
    } tangent_t;

    // One directed row; chk_* holds the hand-read result of the first
    // element of the run, checked only when has_chk is set.
    typedef struct {
        logic signed [23:0] ec;
        logic signed [23:0] eb;
        logic signed [23:0] ea;
        logic signed [15:0] lc;
        logic signed [15:0] rc;
        logic               last;
        logic               has_chk;
        logic signed [15:0] chk_comp;
        logic               chk_zero;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] energy_center = '0;
    logic signed [23:0] energy_before = '0;
    logic signed [23:0] energy_after = '0;
    logic signed [15:0] left_component = '0;
    logic signed [15:0] right_component = '0;
    logic last_element = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] tangent_component;
    logic zero_norm;
    logic last_result;

    // Predictor state: weights, combined elements of the open run.
    logic signed [24:0] w_left, w_right;
    logic signed [40:0] combined_run[$];
    logic               run_open;
    tangent_t           tangent_queue[$];
    int                 fail_count = 0;
    logic               hold_off = 1'b0;
    row_t               rows[N_DIRECT];

    always #10 clk = ~clk;

    uphill_tangent_normalizer #(.MAX_DIM(MAX_DIM)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .energy_center(energy_center), .energy_before(energy_before),
        .energy_after(energy_after),
        .left_component(left_component), .right_component(right_component),
        .last_element(last_element),
        .out_valid(out_valid), .out_stall(out_stall),
        .tangent_component(tangent_component), .zero_norm(zero_norm),
        .last_result(last_result)
    );

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] abs_val(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Choose weights from the three energies under the uphill rule.
    task automatic choose_weights(input logic signed [23:0] ec,
                                  input logic signed [23:0] eb,
                                  input logic signed [23:0] ea);
        logic signed [24:0] dl, dr, hi, lo;
        dl = ec >= eb ? ec - eb : eb - ec;
        dr = ec >= ea ? ec - ea : ea - ec;
        hi = dl > dr ? dl : dr;
        lo = dl > dr ? dr : dl;
        if ((ec >= eb && ec >= ea) || (ec <= eb && ec <= ea))
        begin
            w_left  = eb > ea ? hi : lo;
            w_right = eb > ea ? -lo : -hi;
        end
        else if (eb > ea)
        begin
            w_left = 1; w_right = 0;
        end
        else
        begin
            w_left = 0; w_right = -1;
        end
    endtask

    function automatic logic [63:0] scaled(input logic [63:0] a, input int b);
        return b > 24 ? a >> (b - 24) : a << (24 - b);
    endfunction

    // Fold one accepted element in; on the last one, queue the unit tangent.
    task automatic predict_element(input logic signed [23:0] ec,
                                   input logic signed [23:0] eb,
                                   input logic signed [23:0] ea,
                                   input logic signed [15:0] lc,
                                   input logic signed [15:0] rc,
                                   input logic last);
        logic [63:0] peak, sq, root, s, q;
        logic signed [63:0] c;
        logic signed [40:0] cval;
        int b, n;
        tangent_t t;
        if (!run_open)
        begin
            choose_weights(ec, eb, ea);
            combined_run.delete();
            run_open = 1'b1;
        end
        cval = 41'(w_left) * 41'(lc) + 41'(w_right) * 41'(rc);
        if (combined_run.size() < MAX_DIM)
            combined_run.insert(combined_run.size(), cval);
        if (!last)
            return;
        n = combined_run.size();
        peak = 0;
        foreach (combined_run[k])
            if (abs_val(combined_run[k]) > peak) peak = abs_val(combined_run[k]);
        b = 0;
        for (int i = 0; i < 64; i++)
            if (peak[i]) b = i + 1;
        sq = 0;
        foreach (combined_run[k])
        begin
            s = scaled(abs_val(combined_run[k]), b);
            sq += s * s;
        end
        root = int_sqrt(sq);
        for (int k = 0; k < n; k++)
        begin
            c = combined_run[k];
            t.comp = 0;
            if (peak != 0 && root != 0)
            begin
                s = scaled(abs_val(c), b);
                q = (s * 16384 + (root >> 1)) / root;
                t.comp = c < 0 ? 16'(-q) : 16'(q);
            end
            t.zero = (peak == 0);
            t.last = (k == n - 1);
            tangent_queue.insert(tangent_queue.size(), t);
        end
        run_open = 1'b0;
    endtask

    // Offer one item and hold it until accepted; gaps before it are random.
    task automatic send_item(input logic signed [23:0] ec, input logic signed [23:0] eb,
                             input logic signed [23:0] ea, input logic signed [15:0] lc,
                             input logic signed [15:0] rc, input logic last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        energy_center   <= ec;
        energy_before   <= eb;
        energy_after    <= ea;
        left_component  <= lc;
        right_component <= rc;
        last_element    <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_element(ec, eb, ea, lc, rc, last);
    endtask

    function automatic logic signed [23:0] rand_energy();
        unique case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1: return $signed(24'($urandom_range(0, 200))) - 100;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_comp();
        unique case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: random stall, one long hold-off, check each item.
    initial
    begin
        tangent_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall && rst_n)
            begin
                if (tangent_queue.size() == 0)
                    report("unexpected item", tangent_component, 0);
                else
                begin
                    want = tangent_queue.pop_front();
                    if (tangent_component !== want.comp)
                        report("tangent_component", tangent_component, want.comp);
                    if (zero_norm !== want.zero)
                        report("zero_norm", zero_norm, want.zero);
                    if (last_result !== want.last)
                        report("last_result", last_result, want.last);
                end
            end
            if (hold_off)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 2) == 0)
                out_stall <= 1'($urandom_range(0, 1));
            else
                out_stall <= 1'b0;
        end
    end

    // Hold the output off for a long stretch so the queue fills and the
    // input stalls while items keep being offered.
    initial
    begin
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int len, qlast;
        run_open = 1'b0;
        // Directed rows: extremes, each weight branch, zero vector, equal energies.
        rows[0]  = '{24'sd0, 24'sd0, 24'sd0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'sd0, 1'b1};
        rows[1]  = '{24'sd0, 24'sd100, 24'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 1'b1};
        rows[2]  = '{24'sd0, 24'sd10, -24'sd10, 16'sd100, 16'sd7, 1'b1, 1'b1, 16'sd16384, 1'b0};
        rows[3]  = '{24'sd0, -24'sd10, 24'sd10, 16'sd3, 16'sd100, 1'b1, 1'b1, -16'sd16384, 1'b0};
        rows[4]  = '{24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'sh7FFF, 16'sh8000, 1'b0,
                     1'b0, 0, 0};
        rows[5]  = '{24'sd0, 24'sd0, 24'sd0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 0, 0};
        rows[6]  = '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFF0, 16'sd1, -16'sd1, 1'b0, 1'b0, 0, 0};
        rows[7]  = '{24'sd5, 24'sd5, 24'sd5, 16'sh7FFF, 16'sd0, 1'b0, 1'b0, 0, 0};
        rows[8]  = '{24'sd0, 24'sd0, 24'sd0, -16'sd1, 16'sh7FFF, 1'b1, 1'b0, 0, 0};
        rows[9]  = '{24'sd100, 24'sd50, 24'sd90, 16'sd1234, -16'sd4321, 1'b0, 1'b0, 0, 0};
        rows[10] = '{24'sd100, 24'sd50, 24'sd90, 16'sd0, 16'sd0, 1'b1, 1'b0, 0, 0};
        rows[11] = '{24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 0, 0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_item(rows[i].ec, rows[i].eb, rows[i].ea, rows[i].lc, rows[i].rc, rows[i].last);
            // Single-element runs: the tangent just queued is the hand-read one.
            if (rows[i].has_chk)
            begin
                qlast = tangent_queue.size() - 1;
                if (tangent_queue[qlast].comp !== rows[i].chk_comp)
                    report("directed tangent", tangent_queue[qlast].comp, rows[i].chk_comp);
                if (tangent_queue[qlast].zero !== rows[i].chk_zero)
                    report("directed zero", tangent_queue[qlast].zero, rows[i].chk_zero);
            end
        end

        // One oversize run drops everything past MAX_DIM.
        for (int k = 0; k < MAX_DIM + 3; k++)
            send_item(rand_energy(), rand_energy(), rand_energy(), rand_comp(), rand_comp(),
                      k == MAX_DIM + 2);

        // Random runs: mostly short vectors, a few of 40 up to MAX_DIM elements.
        for (int sent = 0; sent < 320; sent += len)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, MAX_DIM)
                                               : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_item(rand_energy(), rand_energy(), rand_energy(), rand_comp(),
                          rand_comp(), k == len - 1);
        end
        in_valid <= 1'b0;

        while (tangent_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
